### hdl/bse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the blurred Sobel edge map unit.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // item codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 11'd100;
    localparam logic [CFG_W-1:0] WIDTH_RST     = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST    = 11'd480;

    // luma weights, scale 256
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    localparam int LUMA_W = 16;
    localparam int BLUR_W = 20;
    localparam int GRAD_W = 22;

    localparam int FIFO_DEPTH = 16;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic edge_res;
        logic end_of_row;
        logic end_of_frame;
    } t_out_item;

    typedef struct packed {
        logic eor;
        logic eof;
    } t_line_flags;

endpackage

### hdl/bse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bse_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_cell
// One 3x3 window cell: two-row line store, column registers and border
// clamping. Takes one raster token, hands out the clamped window of the
// token W+1 positions earlier. o_win[c][r]: c = left..right, r = top..bottom.
// ----------------------------------------------------------------------------
module bse_cell #(
    parameter int DW    = 16,
    parameter int MAX_W = bse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_H = bse_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_restart,
    input  logic [$clog2(MAX_W)-1:0]           i_width_m1,
    input  logic [$clog2(MAX_H+3)-1:0]         i_height,
    input  logic [$clog2(MAX_W)-1:0]           i_last_col,
    input  logic [$clog2(MAX_H+3)-1:0]         i_last_row,
    input  logic                               i_valid,
    input  logic [DW-1:0]                      i_data,
    output logic                               o_valid,
    output logic [2:0][2:0][DW-1:0]            o_win,
    output bse_pkg::t_line_flags               o_flags
);

    localparam int XW = $clog2(MAX_W);
    localparam int YW = $clog2(MAX_H+3);

    logic [XW-1:0] r_tx;
    logic [YW-1:0] r_ty;
    logic          at_last;

    logic          r_s1_valid;
    logic [DW-1:0] r_s1_data;
    logic [XW-1:0] r_s1_x;
    logic          r_s1_top_clamp;
    logic          r_s1_bot_clamp;
    logic          r_s1_x0;
    logic          r_s1_x1;
    logic          r_s1_emit;
    logic          r_s1_eof;

    logic [2*DW-1:0]       rd_data;
    logic [DW-1:0]         mid_raw;
    logic [DW-1:0]         top_raw;
    logic [2:0][DW-1:0]    cur;
    logic [2:0][DW-1:0]    r_p1;
    logic [2:0][DW-1:0]    r_p2;
    logic [2:0][2:0][DW-1:0] win;
    logic [2:0][2:0][DW-1:0] r_win;
    logic                  r_o_valid;
    bse_pkg::t_line_flags  r_flags;

    assign at_last = (r_tx == i_last_col) && (r_ty == i_last_row);

    // token position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_tx <= '0;
            r_ty <= '0;
        end else if (i_valid) begin
            if (at_last) begin
                r_tx <= '0;
                r_ty <= '0;
            end else if (r_tx == i_width_m1) begin
                r_tx <= '0;
                r_ty <= r_ty + YW'(1);
            end else begin
                r_tx <= r_tx + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_data      <= i_data;
        r_s1_x         <= r_tx;
        r_s1_top_clamp <= (r_ty == YW'(1));
        r_s1_bot_clamp <= (r_ty == i_height);
        r_s1_x0        <= (r_tx == '0);
        r_s1_x1        <= (r_tx == XW'(1));
        r_s1_emit      <= (r_ty >= YW'(2)) || ((r_ty == YW'(1)) && (r_tx != '0));
        r_s1_eof       <= (r_tx == '0) && (r_ty == i_height + YW'(1));
    end

    // line store holds {row y-1, row y-2} per column
    bse_ram #(
        .DW    (2*DW),
        .DEPTH (MAX_W)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_x),
        .i_wdata ({r_s1_data, mid_raw}),
        .i_raddr (r_tx),
        .o_rdata (rd_data)
    );

    assign mid_raw = rd_data[2*DW-1:DW];
    assign top_raw = rd_data[DW-1:0];

    always_comb begin
        cur[0] = r_s1_top_clamp ? mid_raw : top_raw;
        cur[1] = mid_raw;
        cur[2] = r_s1_bot_clamp ? mid_raw : r_s1_data;
    end

    // horizontal clamp: left border repeats column 0, right border repeats W-1
    always_comb begin
        if (r_s1_x0) begin
            win[0] = r_p1;
            win[1] = r_p2;
            win[2] = r_p2;
        end else if (r_s1_x1) begin
            win[0] = r_p2;
            win[1] = r_p2;
            win[2] = cur;
        end else begin
            win[0] = r_p1;
            win[1] = r_p2;
            win[2] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_p1  <= r_p2;
            r_p2  <= cur;
            r_win <= win;
            r_flags.eor <= r_s1_x0;
            r_flags.eof <= r_s1_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_s1_valid && r_s1_emit;
        end
    end

    assign o_valid = r_o_valid;
    assign o_win   = r_win;
    assign o_flags = r_flags;

endmodule

### hdl/blurred_sobel_edge_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blurred_sobel_edge_map_unit
// Luma, 3x3 binomial blur and Sobel magnitude threshold over a pixel stream.
// ----------------------------------------------------------------------------
// Input items arrive on i_in_valid / o_in_stall in raster order: pixel items
// carry RGB, drain items flush the last 2*W+2 results after a frame. Each
// result leaves on o_out_valid / i_out_stall with the edge bit and row/frame
// end marks. Result k appears for the input pixel k+2*W+2 or for a drain item.
// Throughput is one item per cycle while o_in_stall is low. A result reaches
// the output queue through ten register stages, the first loaded at the
// accepting edge: input register, luma, two window cells (each a line store
// read plus a window register), the blur adder, and the gradient, square and
// queue write stages.
// Results collect in a 16-entry output queue; a credit counter holds the input
// stalled only when every queue slot is spoken for, so a stalled receiver
// does not stop input until the credits run out.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while the
// block is idle; writing the width or height restarts the frame.
// Reset (synchronous, active low) loads default sizes and threshold, clears
// positions, queue and credits. Line stores need no clearing.
// ----------------------------------------------------------------------------
module blurred_sobel_edge_map_unit #(
    parameter int MAX_WIDTH  = bse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bse_pkg::MAX_HEIGHT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  bse_pkg::t_in_item        i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output bse_pkg::t_out_item       o_out_item,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [bse_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT+3);
    localparam int FD = bse_pkg::FIFO_DEPTH;
    localparam int FA = $clog2(bse_pkg::FIFO_DEPTH);
    localparam int LW = bse_pkg::LUMA_W;
    localparam int BW = bse_pkg::BLUR_W;
    localparam int GW = bse_pkg::GRAD_W;

    // configuration
    logic [bse_pkg::CFG_W-1:0] r_thr;
    logic [bse_pkg::CFG_W-1:0] r_width;
    logic [bse_pkg::CFG_W-1:0] r_height;
    logic [2*bse_pkg::CFG_W-1:0] r_thr_sq;
    logic                      restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= bse_pkg::THRESHOLD_RST;
            r_width  <= bse_pkg::WIDTH_RST;
            r_height <= bse_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bse_pkg::REG_THRESHOLD: r_thr    <= i_cfg_data;
                bse_pkg::REG_WIDTH:     r_width  <= i_cfg_data;
                bse_pkg::REG_HEIGHT:    r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_sq <= (2*bse_pkg::CFG_W)'(r_thr) * (2*bse_pkg::CFG_W)'(r_thr);
    end

    assign restart = i_cfg_we &&
                     ((i_cfg_idx == bse_pkg::REG_WIDTH) || (i_cfg_idx == bse_pkg::REG_HEIGHT));

    // sizes in use, clamped to [3, MAX]
    logic [31:0]   w_lim;
    logic [31:0]   h_lim;
    logic [XW-1:0] width_m1;
    logic [YW-1:0] height;
    logic [YW-1:0] row_p1;
    logic [YW-1:0] row_p2;

    always_comb begin
        if (32'(r_width) < 32'd3) begin
            w_lim = 32'd3;
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_lim = 32'(MAX_WIDTH);
        end else begin
            w_lim = 32'(r_width);
        end
        if (32'(r_height) < 32'd3) begin
            h_lim = 32'd3;
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_lim = 32'(MAX_HEIGHT);
        end else begin
            h_lim = 32'(r_height);
        end
    end

    assign width_m1 = XW'(w_lim - 32'd1);
    assign height   = YW'(h_lim);
    assign row_p1   = height + YW'(1);
    assign row_p2   = height + YW'(2);

    // input side
    logic          acc;
    logic          is_pixel;
    logic          tok;
    logic          res;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic          in_frame;

    assign acc      = i_in_valid && !o_in_stall;
    assign is_pixel = (i_in_item.opcode == bse_pkg::OP_PIXEL);
    assign in_frame = (r_row < height);
    assign tok      = is_pixel ? in_frame : !in_frame;
    assign res      = is_pixel ?
                      (in_frame && ((r_row >= YW'(3)) ||
                                    ((r_row == YW'(2)) && (r_col >= XW'(2))))) :
                      !in_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc && tok) begin
            if (!is_pixel && (r_col == XW'(1)) && (r_row == row_p2)) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_col == width_m1) begin
                r_col <= '0;
                r_row <= r_row + YW'(1);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    logic       r_in_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= acc && tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= i_in_item.red;
        r_green <= i_in_item.green;
        r_blue  <= i_in_item.blue;
    end

    // luma
    logic          r_luma_valid;
    logic [LW-1:0] r_luma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_valid <= 1'b0;
        end else begin
            r_luma_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_luma <= LW'(r_red) * LW'(bse_pkg::LUMA_R) + LW'(r_green) * LW'(bse_pkg::LUMA_G)
                + LW'(r_blue) * LW'(bse_pkg::LUMA_B);
    end

    // blur cell
    logic                    c1_valid;
    logic [2:0][2:0][LW-1:0] c1_win;
    logic                    r_blur_valid;
    logic [BW-1:0]           r_blur;

    bse_cell #(
        .DW    (LW),
        .MAX_W (MAX_WIDTH),
        .MAX_H (MAX_HEIGHT)
    ) u_cell_blur (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_width_m1 (width_m1),
        .i_height   (height),
        .i_last_col (XW'(1)),
        .i_last_row (row_p2),
        .i_valid    (r_luma_valid),
        .i_data     (r_luma),
        .o_valid    (c1_valid),
        .o_win      (c1_win),
        .o_flags    ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur_valid <= 1'b0;
        end else begin
            r_blur_valid <= c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blur <= BW'(c1_win[0][0]) + (BW'(c1_win[1][0]) << 1) + BW'(c1_win[2][0])
                + (BW'(c1_win[0][1]) << 1) + (BW'(c1_win[1][1]) << 2)
                + (BW'(c1_win[2][1]) << 1)
                + BW'(c1_win[0][2]) + (BW'(c1_win[1][2]) << 1) + BW'(c1_win[2][2]);
    end

    // Sobel cell
    logic                    c2_valid;
    logic [2:0][2:0][BW-1:0] c2_win;
    bse_pkg::t_line_flags    c2_flags;

    bse_cell #(
        .DW    (BW),
        .MAX_W (MAX_WIDTH),
        .MAX_H (MAX_HEIGHT)
    ) u_cell_sobel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_width_m1 (width_m1),
        .i_height   (height),
        .i_last_col ('0),
        .i_last_row (row_p1),
        .i_valid    (r_blur_valid),
        .i_data     (r_blur),
        .o_valid    (c2_valid),
        .o_win      (c2_win),
        .o_flags    (c2_flags)
    );

    logic [GW-1:0] gx_pos;
    logic [GW-1:0] gx_neg;
    logic [GW-1:0] gy_pos;
    logic [GW-1:0] gy_neg;

    assign gx_pos = GW'(c2_win[2][0]) + (GW'(c2_win[2][1]) << 1) + GW'(c2_win[2][2]);
    assign gx_neg = GW'(c2_win[0][0]) + (GW'(c2_win[0][1]) << 1) + GW'(c2_win[0][2]);
    assign gy_pos = GW'(c2_win[0][2]) + (GW'(c2_win[1][2]) << 1) + GW'(c2_win[2][2]);
    assign gy_neg = GW'(c2_win[0][0]) + (GW'(c2_win[1][0]) << 1) + GW'(c2_win[2][0]);

    logic                 r_ga_valid;
    logic [GW-1:0]        r_gx_abs;
    logic [GW-1:0]        r_gy_abs;
    bse_pkg::t_line_flags r_ga_flags;
    logic                 r_sq_valid;
    logic [2*GW-1:0]      r_gx_sq;
    logic [2*GW-1:0]      r_gy_sq;
    bse_pkg::t_line_flags r_sq_flags;
    logic [2*GW:0]        mag;
    logic [2*GW+1:0]      thr_lim;
    bse_pkg::t_out_item   push_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ga_valid <= 1'b0;
            r_sq_valid <= 1'b0;
        end else begin
            r_ga_valid <= c2_valid;
            r_sq_valid <= r_ga_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx_abs   <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        r_gy_abs   <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        r_ga_flags <= c2_flags;
        r_gx_sq    <= (2*GW)'(r_gx_abs) * (2*GW)'(r_gx_abs);
        r_gy_sq    <= (2*GW)'(r_gy_abs) * (2*GW)'(r_gy_abs);
        r_sq_flags <= r_ga_flags;
    end

    // (threshold * 4096)^2 = threshold^2 << 24
    assign mag     = (2*GW+1)'(r_gx_sq) + (2*GW+1)'(r_gy_sq);
    assign thr_lim = {r_thr_sq, 24'd0};

    always_comb begin
        push_item.edge_res     = ((2*GW+2)'(mag) > thr_lim);
        push_item.end_of_row   = r_sq_flags.eor;
        push_item.end_of_frame = r_sq_flags.eof;
    end

    // output queue with credits
    bse_pkg::t_out_item r_fifo [FD];
    logic [FA-1:0]      r_wp;
    logic [FA-1:0]      r_rp;
    logic [FA:0]        r_cnt;
    logic [FA:0]        r_cred;
    logic               push;
    logic               pop;

    assign push = r_sq_valid;
    assign pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_cred <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + FA'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FA'(1);
            end
            r_cnt  <= r_cnt + (FA+1)'(push) - (FA+1)'(pop);
            r_cred <= r_cred + (FA+1)'(acc && res) - (FA+1)'(pop);
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_fifo[r_rp];
    assign o_in_stall  = (r_cred == (FA+1)'(FD));

`ifndef ASSERT_OFF
    a_cnt_le_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_cred)
        else $error("queue holds more results than credits");

    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= (FA+1)'(FD))
        else $error("credit counter over queue depth");

    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && push_item.end_of_frame |-> push_item.end_of_row)
        else $error("frame end without row end");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_row == '0) && (r_col == '0))
        else $error("size write did not restart the frame");
`endif

endmodule
